// ----- hdl/bfsa_pkg.sv -----
// ----------------------------------------------------------------------------
// bfsa_pkg
// Shared types, field layout and codes of the bev scatter-add core.
// ----------------------------------------------------------------------------
package bfsa_pkg;

  // default grid and queue sizes
  localparam int DEF_GRID_X      = 64;
  localparam int DEF_GRID_Y      = 64;
  localparam int DEF_GRID_Z      = 1;
  localparam int DEF_CHANNELS    = 16;
  localparam int DEF_QUEUE_DEPTH = 4;

  // field widths
  localparam int NUM_AXES   = 3;
  localparam int COORD_W    = 32;
  localparam int WEIGHT_W   = 16;
  localparam int FEAT_W     = 16;
  localparam int CHAN_W     = 4;
  localparam int INDEX_W    = 16;
  localparam int ACC_W      = 32;
  localparam int STATUS_W   = 3;
  localparam int FUNC_W     = 2;
  localparam int PROD_W     = WEIGHT_W + FEAT_W + 1;
  localparam int CONTRIB_W  = PROD_W - 10;
  localparam int STORE_DEPTH = 1 << INDEX_W;

  // stream payload layout
  localparam int IN_WEIGHT_LO = NUM_AXES * COORD_W;
  localparam int IN_FEAT_LO   = IN_WEIGHT_LO + WEIGHT_W;
  localparam int IN_CHAN_LO   = IN_FEAT_LO + FEAT_W;
  localparam int IN_RIDX_LO   = IN_CHAN_LO + CHAN_W;
  localparam int IN_USED_W    = IN_RIDX_LO + INDEX_W;
  localparam int IN_DATA_W    = ((IN_USED_W + 7) / 8) * 8;
  localparam int OUT_DATA_W   = ((ACC_W + INDEX_W + 7) / 8) * 8;

  // configuration port
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;
  localparam int REG_IDX_W  = 3;
  localparam logic [REG_IDX_W-1:0] REG_X_ORIGIN    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_Y_ORIGIN    = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_Z_ORIGIN    = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_X_INV_STEP  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_Y_INV_STEP  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_Z_INV_STEP  = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_WEIGHT_FLOOR = 3'd6;

  // item function codes (the spare code reads like a plain read)
  localparam logic [FUNC_W-1:0] FUNC_ACC        = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_READ       = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ_CLEAR = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_ADDED   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_OUTSIDE = 3'd1;
  localparam logic [STATUS_W-1:0] ST_WEAK    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_SAT     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_READ    = 3'd4;

  // work the back end does for one queued item
  typedef enum logic [1:0] {
    OP_ADD,
    OP_READ,
    OP_CLEAR,
    OP_DROP
  } op_t;

  typedef struct packed {
    op_t                         op;
    logic [INDEX_W-1:0]          addr;
    logic signed [CONTRIB_W-1:0] contrib;
    logic [STATUS_W-1:0]         status;
  } qent_t;

  typedef struct packed {
    logic [COORD_W-1:0]  x_origin;
    logic [COORD_W-1:0]  y_origin;
    logic [COORD_W-1:0]  z_origin;
    logic [COORD_W-1:0]  x_inv_step;
    logic [COORD_W-1:0]  y_inv_step;
    logic [COORD_W-1:0]  z_inv_step;
    logic [WEIGHT_W-1:0] weight_floor;
  } cfg_t;

  // back end status seen by the front end
  typedef struct packed {
    logic clearing;
    logic pop;
  } bk_stat_t;

endpackage

// ----- hdl/bev_fixed_point_scatter_add_core.sv -----
// ----------------------------------------------------------------------------
// bev_fixed_point_scatter_add_core
// Bins frustum points into a bird's-eye-view grid and adds weighted features
// into a saturating 32-bit accumulator store; reads return entries.
//
//   channel  direction  handshake          payload
//   in_      sink       tvalid/tready      tdata: point, weight, feature, index
//   out_     source     tvalid/tready      tdata: value, entry; tuser: status
//   cfg_     sink       psel/penable       7 registers at 4*i, pready tied high
//
// After reset a clearing pass zeroes the 65536-entry store with in_tready
// held low; configuration writes are taken throughout. Each item then
// takes a store read in S_IDLE and an update write in S_UPD on the
// single-port store, so the back end takes a new item only once the last
// one's update is written, and S_UPD waits while a result stalls.
// The output register holds a stalled result; the front end keeps accepting
// until the front pipeline and queue hold QUEUE_DEPTH items.
// ----------------------------------------------------------------------------
module bev_fixed_point_scatter_add_core #(
  parameter int GRID_X      = bfsa_pkg::DEF_GRID_X,
  parameter int GRID_Y      = bfsa_pkg::DEF_GRID_Y,
  parameter int GRID_Z      = bfsa_pkg::DEF_GRID_Z,
  parameter int CHANNELS    = bfsa_pkg::DEF_CHANNELS,
  parameter int QUEUE_DEPTH = bfsa_pkg::DEF_QUEUE_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // x_coord, y_coord, z_coord, depth_weight, feature_value, channel,
  // read_index, zero pad
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [bfsa_pkg::IN_DATA_W-1:0]  in_tdata,
  // func
  input  logic [bfsa_pkg::FUNC_W-1:0]     in_tuser,
  // acc_value, entry_index
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [bfsa_pkg::OUT_DATA_W-1:0] out_tdata,
  // status
  output logic [bfsa_pkg::STATUS_W-1:0]   out_tuser,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [bfsa_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [bfsa_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [bfsa_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                            cfg_pready
);
  import bfsa_pkg::*;

  cfg_t     cfg;
  bk_stat_t bk_stat;
  logic     q_push;
  qent_t    q_wdata;
  qent_t    q_rdata;
  logic     q_valid;

  // configuration registers
  bfsa_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  // binning and classification
  bfsa_front #(
    .GRID_X      (GRID_X),
    .GRID_Y      (GRID_Y),
    .GRID_Z      (GRID_Z),
    .CHANNELS    (CHANNELS),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .bk_stat   (bk_stat),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  // item queue
  bfsa_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .wdata     (q_wdata),
    .pop       (bk_stat.pop),
    .rdata     (q_rdata),
    .not_empty (q_valid)
  );

  // store and update sequencer
  bfsa_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_rdata    (q_rdata),
    .bk_stat    (bk_stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

// ----- hdl/bfsa_cfg.sv -----
// ----------------------------------------------------------------------------
// bfsa_cfg
// Register file behind the configuration port: grid origins, reciprocal
// cell sizes and the weight floor.
// ----------------------------------------------------------------------------
module bfsa_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [bfsa_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [bfsa_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [bfsa_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                            cfg_pready,
  output bfsa_pkg::cfg_t                  cfg
);
  import bfsa_pkg::*;

  cfg_t                 cfg_r;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;

  assign reg_idx    = cfg_paddr[CFG_ADDR_W-1:2];
  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg        = cfg_r;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.x_origin     <= '0;
      cfg_r.y_origin     <= '0;
      cfg_r.z_origin     <= '0;
      cfg_r.x_inv_step   <= 32'h0001_0000;
      cfg_r.y_inv_step   <= 32'h0001_0000;
      cfg_r.z_inv_step   <= 32'h0001_0000;
      cfg_r.weight_floor <= 16'd1;
    end else if (wr_en) begin
      case (reg_idx)
        REG_X_ORIGIN:     cfg_r.x_origin     <= cfg_pwdata;
        REG_Y_ORIGIN:     cfg_r.y_origin     <= cfg_pwdata;
        REG_Z_ORIGIN:     cfg_r.z_origin     <= cfg_pwdata;
        REG_X_INV_STEP:   cfg_r.x_inv_step   <= cfg_pwdata;
        REG_Y_INV_STEP:   cfg_r.y_inv_step   <= cfg_pwdata;
        REG_Z_INV_STEP:   cfg_r.z_inv_step   <= cfg_pwdata;
        REG_WEIGHT_FLOOR: cfg_r.weight_floor <= cfg_pwdata[WEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (reg_idx)
      REG_X_ORIGIN:     cfg_prdata = cfg_r.x_origin;
      REG_Y_ORIGIN:     cfg_prdata = cfg_r.y_origin;
      REG_Z_ORIGIN:     cfg_prdata = cfg_r.z_origin;
      REG_X_INV_STEP:   cfg_prdata = cfg_r.x_inv_step;
      REG_Y_INV_STEP:   cfg_prdata = cfg_r.y_inv_step;
      REG_Z_INV_STEP:   cfg_prdata = cfg_r.z_inv_step;
      REG_WEIGHT_FLOOR: cfg_prdata = CFG_DATA_W'(cfg_r.weight_floor);
      default:          cfg_prdata = '0;
    endcase
  end

endmodule

// ----- hdl/bfsa_front.sv -----
// ----------------------------------------------------------------------------
// bfsa_front
// Accepts items, bins the point on three axes, forms the weighted
// contribution and classifies each item into one queue entry.
// ----------------------------------------------------------------------------
module bfsa_front #(
  parameter int GRID_X      = bfsa_pkg::DEF_GRID_X,
  parameter int GRID_Y      = bfsa_pkg::DEF_GRID_Y,
  parameter int GRID_Z      = bfsa_pkg::DEF_GRID_Z,
  parameter int CHANNELS    = bfsa_pkg::DEF_CHANNELS,
  parameter int QUEUE_DEPTH = bfsa_pkg::DEF_QUEUE_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  bfsa_pkg::cfg_t                 cfg,
  input  bfsa_pkg::bk_stat_t             bk_stat,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [bfsa_pkg::IN_DATA_W-1:0] in_tdata,
  input  logic [bfsa_pkg::FUNC_W-1:0]    in_tuser,
  output logic                           q_push,
  output bfsa_pkg::qent_t                q_wdata
);
  import bfsa_pkg::*;

  localparam int CRED_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CRED_W-1:0] CRED_MAX = CRED_W'(QUEUE_DEPTH);
  localparam logic [NUM_AXES-1:0][COORD_W-1:0] LIMIT =
    {COORD_W'(GRID_Z), COORD_W'(GRID_Y), COORD_W'(GRID_X)};
  localparam logic [INDEX_W-1:0] GZ_W    = INDEX_W'(GRID_Z);
  localparam logic [INDEX_W-1:0] GY_W    = INDEX_W'(GRID_Y);
  localparam logic [INDEX_W-1:0] PLANE_W = INDEX_W'(GRID_X * GRID_Y);

  logic [CRED_W-1:0] cred_r;
  logic              accept;

  logic [NUM_AXES-1:0][COORD_W-1:0] coord;
  logic [NUM_AXES-1:0][COORD_W-1:0] origin;
  logic [NUM_AXES-1:0][COORD_W-1:0] inv;
  logic [NUM_AXES-1:0][COORD_W:0]   diff;
  logic [NUM_AXES-1:0][2*COORD_W-1:0] mprod;

  // stage 1: offsets from the origin
  logic                             s1_v_r;
  logic [FUNC_W-1:0]                s1_func_r;
  logic [NUM_AXES-1:0][COORD_W:0]   s1_diff_r;
  logic [WEIGHT_W-1:0]              s1_weight_r;
  logic signed [FEAT_W-1:0]         s1_feat_r;
  logic [CHAN_W-1:0]                s1_chan_r;
  logic [INDEX_W-1:0]               s1_ridx_r;

  // stage 2: scaled offsets and weighted feature
  logic                             s2_v_r;
  logic [FUNC_W-1:0]                s2_func_r;
  logic [NUM_AXES-1:0]              s2_neg_r;
  logic [NUM_AXES-1:0]              s2_izero_r;
  logic [NUM_AXES-1:0][COORD_W-1:0] s2_hi_r;
  logic signed [PROD_W-1:0]         s2_prod_r;
  logic [WEIGHT_W-1:0]              s2_weight_r;
  logic [CHAN_W-1:0]                s2_chan_r;
  logic [INDEX_W-1:0]               s2_ridx_r;

  logic signed [WEIGHT_W:0]         weight_s;
  logic [NUM_AXES-1:0]              axis_ok;
  logic [NUM_AXES-1:0][INDEX_W-1:0] cell_idx;
  logic                             chan_ok;
  logic [INDEX_W-1:0]               entry_addr;
  logic signed [PROD_W-1:0]         prod_adj;

  // credits cover both stages plus the queue, so a push never overflows
  assign in_tready = !bk_stat.clearing && (cred_r < CRED_MAX);
  assign accept    = in_tvalid && in_tready;

  assign coord  = in_tdata[NUM_AXES*COORD_W-1:0];
  assign origin = {cfg.z_origin, cfg.y_origin, cfg.x_origin};
  assign inv    = {cfg.z_inv_step, cfg.y_inv_step, cfg.x_inv_step};

  // per-axis offset, kept one bit wider for the sign
  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      diff[a] = {coord[a][COORD_W-1], coord[a]} - {origin[a][COORD_W-1], origin[a]};
    end
  end

  // per-axis offset times reciprocal step
  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      mprod[a] = (2*COORD_W)'(s1_diff_r[a][COORD_W-1:0]) * (2*COORD_W)'(inv[a]);
    end
  end

  assign weight_s = {1'b0, s1_weight_r};

  // control: credits and stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cred_r <= '0;
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= accept;
      s2_v_r <= s1_v_r;
      case ({accept, bk_stat.pop})
        2'b10:   cred_r <= cred_r + CRED_W'(1);
        2'b01:   cred_r <= cred_r - CRED_W'(1);
        default: cred_r <= cred_r;
      endcase
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    s1_func_r   <= in_tuser;
    s1_diff_r   <= diff;
    s1_weight_r <= in_tdata[IN_WEIGHT_LO +: WEIGHT_W];
    s1_feat_r   <= in_tdata[IN_FEAT_LO +: FEAT_W];
    s1_chan_r   <= in_tdata[IN_CHAN_LO +: CHAN_W];
    s1_ridx_r   <= in_tdata[IN_RIDX_LO +: INDEX_W];

    s2_func_r   <= s1_func_r;
    s2_weight_r <= s1_weight_r;
    s2_chan_r   <= s1_chan_r;
    s2_ridx_r   <= s1_ridx_r;
    s2_prod_r   <= weight_s * s1_feat_r;
    for (int a = 0; a < NUM_AXES; a++) begin
      s2_neg_r[a]   <= s1_diff_r[a][COORD_W];
      s2_izero_r[a] <= (inv[a] == '0);
      s2_hi_r[a]    <= mprod[a][2*COORD_W-1:COORD_W];
    end
  end

  // grid test per axis; below the origin only a zero step keeps the point
  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      if (s2_neg_r[a]) begin
        axis_ok[a]  = s2_izero_r[a];
        cell_idx[a] = '0;
      end else begin
        axis_ok[a]  = (s2_hi_r[a] < LIMIT[a]);
        cell_idx[a] = s2_hi_r[a][INDEX_W-1:0];
      end
    end
  end

  assign chan_ok = (COORD_W'(s2_chan_r) < COORD_W'(CHANNELS));

  // entry address, wrapped to the store size
  assign entry_addr = (INDEX_W'(s2_chan_r) * GZ_W + cell_idx[2]) * PLANE_W
                    + cell_idx[0] * GY_W + cell_idx[1];

  // divide by 1024 rounding toward zero
  assign prod_adj = s2_prod_r + (s2_prod_r[PROD_W-1] ? PROD_W'(1023) : PROD_W'(0));

  // classify into a queue entry
  always_comb begin
    q_wdata.op      = OP_READ;
    q_wdata.addr    = s2_ridx_r;
    q_wdata.contrib = prod_adj[PROD_W-1:10];
    q_wdata.status  = ST_READ;
    case (s2_func_r)
      FUNC_ACC: begin
        if (!(&axis_ok) || !chan_ok) begin
          q_wdata.op     = OP_DROP;
          q_wdata.addr   = '0;
          q_wdata.status = ST_OUTSIDE;
        end else if (s2_weight_r < cfg.weight_floor) begin
          q_wdata.op     = OP_DROP;
          q_wdata.addr   = '0;
          q_wdata.status = ST_WEAK;
        end else begin
          q_wdata.op     = OP_ADD;
          q_wdata.addr   = entry_addr;
          q_wdata.status = ST_ADDED;
        end
      end
      FUNC_READ_CLEAR: q_wdata.op = OP_CLEAR;
      default:         q_wdata.op = OP_READ;
    endcase
  end

  assign q_push = s2_v_r;

endmodule

// ----- hdl/bfsa_fifo.sv -----
// ----------------------------------------------------------------------------
// bfsa_fifo
// Short queue of classified items between the front and back ends.
// ----------------------------------------------------------------------------
module bfsa_fifo #(
  parameter int DEPTH = bfsa_pkg::DEF_QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  bfsa_pkg::qent_t wdata,
  input  logic            pop,
  output bfsa_pkg::qent_t rdata,
  output logic            not_empty
);
  import bfsa_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  qent_t             slot_r [DEPTH];
  logic [PTR_W-1:0]  wptr_r;
  logic [PTR_W-1:0]  rptr_r;
  logic [CNT_W-1:0]  count_r;

  assign rdata     = slot_r[rptr_r];
  assign not_empty = (count_r != '0);

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (push) wptr_r <= (wptr_r == PTR_LAST) ? '0 : wptr_r + PTR_W'(1);
      if (pop)  rptr_r <= (rptr_r == PTR_LAST) ? '0 : rptr_r + PTR_W'(1);
      case ({push, pop})
        2'b10:   count_r <= count_r + CNT_W'(1);
        2'b01:   count_r <= count_r - CNT_W'(1);
        default: count_r <= count_r;
      endcase
    end
  end

  // slot storage
  always_ff @(posedge clk) begin
    if (push) slot_r[wptr_r] <= wdata;
  end

endmodule

// ----- hdl/bfsa_back.sv -----
// ----------------------------------------------------------------------------
// bfsa_back
// Accumulator store and its read-modify-write sequencer: clearing pass
// after reset, then a store read and an update write per item.
// ----------------------------------------------------------------------------
module bfsa_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            q_valid,
  input  bfsa_pkg::qent_t                 q_rdata,
  output bfsa_pkg::bk_stat_t              bk_stat,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [bfsa_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic [bfsa_pkg::STATUS_W-1:0]   out_tuser
);
  import bfsa_pkg::*;

  typedef enum logic [1:0] {
    S_CLR,
    S_IDLE,
    S_UPD
  } state_t;

  localparam logic [INDEX_W-1:0] CLR_LAST = '1;
  localparam logic [ACC_W-1:0]   ACC_MAX  = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic [ACC_W-1:0]   ACC_MIN  = {1'b1, {(ACC_W-1){1'b0}}};

  state_t              state_r;
  logic [INDEX_W-1:0]  clr_cnt_r;
  qent_t               cur_r;
  logic [ACC_W-1:0]    store_mem [STORE_DEPTH];
  logic [ACC_W-1:0]    rd_data_r;

  logic                out_tvalid_r;
  logic [ACC_W-1:0]    out_acc_r;
  logic [INDEX_W-1:0]  out_idx_r;
  logic [STATUS_W-1:0] out_status_r;

  logic                pop;
  logic                out_load;
  logic                mem_we;
  logic [INDEX_W-1:0]  mem_wa;
  logic [ACC_W-1:0]    mem_wd;
  logic [ACC_W:0]      sum;
  logic                sum_ovf;
  logic [ACC_W-1:0]    sat_val;
  logic [ACC_W-1:0]    res_acc;
  logic [INDEX_W-1:0]  res_idx;
  logic [STATUS_W-1:0] res_status;

  assign pop      = (state_r == S_IDLE) && q_valid;
  assign out_load = (state_r == S_UPD) && (!out_tvalid_r || out_tready);

  assign bk_stat.clearing = (state_r == S_CLR);
  assign bk_stat.pop      = pop;

  // saturating add of the contribution
  assign sum     = {rd_data_r[ACC_W-1], rd_data_r}
                 + {{(ACC_W + 1 - CONTRIB_W){cur_r.contrib[CONTRIB_W-1]}}, cur_r.contrib};
  assign sum_ovf = (sum[ACC_W] != sum[ACC_W-1]);
  assign sat_val = sum_ovf ? (sum[ACC_W] ? ACC_MIN : ACC_MAX) : sum[ACC_W-1:0];

  // result of the current item
  always_comb begin
    case (cur_r.op)
      OP_ADD: begin
        res_acc    = sat_val;
        res_idx    = cur_r.addr;
        res_status = sum_ovf ? ST_SAT : ST_ADDED;
      end
      OP_READ, OP_CLEAR: begin
        res_acc    = rd_data_r;
        res_idx    = cur_r.addr;
        res_status = ST_READ;
      end
      default: begin
        res_acc    = '0;
        res_idx    = '0;
        res_status = cur_r.status;
      end
    endcase
  end

  // store write port: clearing sweep, or the update as the result is issued
  always_comb begin
    if (state_r == S_CLR) begin
      mem_we = 1'b1;
      mem_wa = clr_cnt_r;
      mem_wd = '0;
    end else begin
      mem_we = out_load && ((cur_r.op == OP_ADD) || (cur_r.op == OP_CLEAR));
      mem_wa = cur_r.addr;
      mem_wd = (cur_r.op == OP_ADD) ? sat_val : '0;
    end
  end

  // accumulator store, registered read at pop
  always_ff @(posedge clk) begin
    if (mem_we) store_mem[mem_wa] <= mem_wd;
    if (pop)    rd_data_r <= store_mem[q_rdata.addr];
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLR;
      clr_cnt_r    <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      // result register fills on an update, empties when taken
      if (out_load) out_tvalid_r <= 1'b1;
      else if (out_tready) out_tvalid_r <= 1'b0;
      case (state_r)
        S_CLR: begin
          clr_cnt_r <= clr_cnt_r + INDEX_W'(1);
          if (clr_cnt_r == CLR_LAST) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (pop) begin
            cur_r   <= q_rdata;
            state_r <= S_UPD;
          end
        end
        S_UPD: begin
          if (out_load) begin
            out_acc_r    <= res_acc;
            out_idx_r    <= res_idx;
            out_status_r <= res_status;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = OUT_DATA_W'({out_idx_r, out_acc_r});
  assign out_tuser  = out_status_r;

endmodule

// ----- hdl/bfsa_checker.sv -----
// ----------------------------------------------------------------------------
// bfsa_checker
// Port-level checks of the scatter-add core, bound to the top level.
// ----------------------------------------------------------------------------
module bfsa_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [bfsa_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic [bfsa_pkg::STATUS_W-1:0]   out_tuser
);
  import bfsa_pkg::*;

  // the clearing pass keeps the input closed right after reset
  a_closed_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_tready)
    else $error("input open right after reset");

  // a dropped point reports zero value and zero entry
  a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_OUTSIDE || out_tuser == ST_WEAK)
      |-> out_tdata == '0)
    else $error("dropped item with non-zero payload");

  // a saturated sum sits at one end of the 32-bit range
  a_sat_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_SAT
      |-> out_tdata[ACC_W-1:0] == 32'h7fff_ffff || out_tdata[ACC_W-1:0] == 32'h8000_0000)
    else $error("saturated result not clamped");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready
      |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

endmodule

bind bev_fixed_point_scatter_add_core bfsa_checker u_bfsa_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
